[rtl/core/sttkt_pkg.sv]
`default_nettype none
package sttkt_pkg;

    localparam logic [3:0] FN_GET          = 4'd0;
    localparam logic [3:0] FN_ADD          = 4'd1;
    localparam logic [3:0] FN_REMOVE       = 4'd2;
    localparam logic [3:0] FN_UPDATE       = 4'd3;
    localparam logic [3:0] FN_UPDATE_ALL   = 4'd4;
    localparam logic [3:0] FN_IS_MEMBER    = 4'd5;
    localparam logic [3:0] FN_BLOCK_ADD    = 4'd6;
    localparam logic [3:0] FN_BLOCK_FIND   = 4'd7;
    localparam logic [3:0] FN_BLOCK_REMOVE = 4'd8;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] user_key;
        logic signed [31:0] page_id;
        logic [7:0]         entry_state;
        logic [7:0]         target_state;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic               table_full;
        logic signed [31:0] found_key;
        logic signed [31:0] found_page;
        logic [7:0]         found_state;
    } t_resp;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] page;
        logic [7:0]  state;
    } t_ent;

    typedef enum logic [1:0] {TB_PRIM, TB_SECD, TB_BLKD, TB_SNAP} t_tbl;

    typedef enum logic [2:0] {
        PO_FIND, PO_UPSERT, PO_ERASE, PO_SETST, PO_COPY, PO_RDSNAP
    } t_pop;

    typedef struct packed {
        t_pop op;
        t_tbl tbl;
        t_ent ent;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic full;
        t_ent ent;
    } t_res;

    typedef enum logic [3:0] {
        E_IDLE, E_SRCH, E_SRCH_CMP, E_CHK, E_POST, E_SHUP_RD, E_SHUP_WR, E_WRITE,
        E_SHDN_RD, E_SHDN_WR, E_COPY_RD, E_COPY_WR, E_SNAP_DATA, E_DONE
    } t_est;

    typedef enum logic [1:0] {T_IDLE, T_WAIT, T_UA_NEXT, T_FINISH} t_tst;

    typedef enum logic [3:0] {
        ST_GET_P, ST_GET_S, ST_ONE_UP, ST_ONE_HIT, ST_RM_P, ST_UPD_P, ST_UPD_S,
        ST_UA_COPY, ST_UA_SNAP, ST_UA_FIND, ST_UA_SET, ST_UA_RMP, ST_UA_RMS, ST_UA_ADD
    } t_step;

    function automatic t_cmd mk_cmd(t_pop op, t_tbl tbl, logic [31:0] key,
                                    logic [31:0] page, logic [7:0] state);
        t_cmd c;
        c.op        = op;
        c.tbl       = tbl;
        c.ent.key   = key;
        c.ent.page  = page;
        c.ent.state = state;
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/sttkt_ram.sv]
`default_nettype none
module sttkt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/sttkt_engine.sv]
`default_nettype none
module sttkt_engine
    import sttkt_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire t_cmd                         i_cmd,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_idx,
    output logic                              o_done,
    output t_res                              o_res,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int W_IDX  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CNT  = $clog2(DEPTH + 1);
    localparam int W_ADDR = W_IDX + 2;
    localparam logic [W_CNT-1:0] FULL_CNT = W_CNT'(DEPTH);
    localparam logic [W_CNT-1:0] ONE      = W_CNT'(1);

    t_est             r_st, n_st;
    t_pop             r_op, n_op;
    t_tbl             r_tbl, n_tbl;
    t_ent             r_wr, n_wr;
    t_ent             r_ent, n_ent;
    logic [W_CNT-1:0] r_lo, n_lo, r_hi, n_hi, r_j, n_j, r_pos, n_pos;
    logic             r_found, n_found, r_full, n_full;
    logic [W_CNT-1:0] r_cnt_p, n_cnt_p, r_cnt_s, n_cnt_s, r_cnt_b, n_cnt_b;

    logic              inc, dec;
    logic              we, re;
    logic [W_ADDR-1:0] waddr, raddr;
    t_ent              wdata, q;
    logic [71:0]       rdata;
    logic [W_CNT-1:0]  cur_cnt, mid;

    function automatic logic [W_ADDR-1:0] addr_of(t_tbl t, logic [W_CNT-1:0] i);
        return {t, i[W_IDX-1:0]};
    endfunction

    function automatic logic [W_CNT-1:0] cnt_of(t_tbl t, logic [W_CNT-1:0] p,
                                                logic [W_CNT-1:0] s, logic [W_CNT-1:0] b);
        logic [W_CNT-1:0] c;
        unique case (t)
            TB_PRIM: c = p;
            TB_SECD: c = s;
            TB_BLKD: c = b;
            default: c = '0;
        endcase
        return c;
    endfunction

    sttkt_ram #(.WIDTH($bits(t_ent)), .DEPTH(4 * (2 ** W_IDX))) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign q       = t_ent'(rdata);
    assign cur_cnt = cnt_of(r_tbl, r_cnt_p, r_cnt_s, r_cnt_b);
    assign mid     = W_CNT'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= E_IDLE;
            r_cnt_p <= '0;
            r_cnt_s <= '0;
            r_cnt_b <= '0;
        end else begin
            r_st    <= n_st;
            r_cnt_p <= n_cnt_p;
            r_cnt_s <= n_cnt_s;
            r_cnt_b <= n_cnt_b;
        end
        r_op    <= n_op;
        r_tbl   <= n_tbl;
        r_wr    <= n_wr;
        r_ent   <= n_ent;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_j     <= n_j;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_full  <= n_full;
    end

    always_comb begin
        n_st = r_st; n_op = r_op; n_tbl = r_tbl; n_wr = r_wr; n_ent = r_ent;
        n_lo = r_lo; n_hi = r_hi; n_j = r_j; n_pos = r_pos;
        n_found = r_found; n_full = r_full;
        inc = 1'b0; dec = 1'b0;
        we = 1'b0; waddr = '0; wdata = r_wr;
        re = 1'b0; raddr = '0;
        o_done = 1'b0;
        unique case (r_st)
            E_IDLE: begin
                if (i_start) begin
                    n_op    = i_cmd.op;
                    n_tbl   = i_cmd.tbl;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    unique case (i_cmd.op)
                        PO_SETST: begin
                            n_wr       = r_ent;
                            n_wr.state = i_cmd.ent.state;
                            n_st       = E_WRITE;
                        end
                        PO_COPY: begin
                            n_j  = '0;
                            n_st = E_COPY_RD;
                        end
                        PO_RDSNAP: begin
                            re    = 1'b1;
                            raddr = addr_of(TB_SNAP, i_idx);
                            n_st  = E_SNAP_DATA;
                        end
                        default: begin
                            n_wr = i_cmd.ent;
                            n_lo = '0;
                            n_hi = cnt_of(i_cmd.tbl, r_cnt_p, r_cnt_s, r_cnt_b);
                            n_st = E_SRCH;
                        end
                    endcase
                end
            end
            E_SRCH: begin
                if (r_lo < r_hi) begin
                    re    = 1'b1;
                    raddr = addr_of(r_tbl, mid);
                    n_j   = mid;
                    n_st  = E_SRCH_CMP;
                end else begin
                    n_pos = r_lo;
                    if (r_lo < cur_cnt) begin
                        re    = 1'b1;
                        raddr = addr_of(r_tbl, r_lo);
                        n_st  = E_CHK;
                    end else begin
                        n_found = 1'b0;
                        n_st    = E_POST;
                    end
                end
            end
            E_SRCH_CMP: begin
                if ($signed(q.key) < $signed(r_wr.key)) begin
                    n_lo = r_j + ONE;
                end else begin
                    n_hi = r_j;
                end
                n_st = E_SRCH;
            end
            E_CHK: begin
                n_found = (q.key == r_wr.key);
                n_ent   = q;
                n_st    = E_POST;
            end
            E_POST: begin
                unique case (r_op)
                    PO_UPSERT: begin
                        if (r_found) begin
                            n_st = E_WRITE;
                        end else if (cur_cnt == FULL_CNT) begin
                            n_full = 1'b1;
                            n_st   = E_DONE;
                        end else begin
                            n_j  = cur_cnt;
                            inc  = 1'b1;
                            n_st = E_SHUP_RD;
                        end
                    end
                    PO_ERASE: begin
                        n_j  = r_pos;
                        n_st = r_found ? E_SHDN_RD : E_DONE;
                    end
                    default: n_st = E_DONE;
                endcase
            end
            E_SHUP_RD: begin
                if (r_j > r_pos) begin
                    re    = 1'b1;
                    raddr = addr_of(r_tbl, r_j - ONE);
                    n_st  = E_SHUP_WR;
                end else begin
                    n_st = E_WRITE;
                end
            end
            E_SHUP_WR: begin
                we    = 1'b1;
                waddr = addr_of(r_tbl, r_j);
                wdata = q;
                n_j   = r_j - ONE;
                n_st  = E_SHUP_RD;
            end
            E_WRITE: begin
                we      = 1'b1;
                waddr   = addr_of(r_tbl, r_pos);
                wdata   = r_wr;
                n_found = 1'b1;
                n_st    = E_DONE;
            end
            E_SHDN_RD: begin
                if (r_j + ONE < cur_cnt) begin
                    re    = 1'b1;
                    raddr = addr_of(r_tbl, r_j + ONE);
                    n_st  = E_SHDN_WR;
                end else begin
                    dec  = 1'b1;
                    n_st = E_DONE;
                end
            end
            E_SHDN_WR: begin
                we    = 1'b1;
                waddr = addr_of(r_tbl, r_j);
                wdata = q;
                n_j   = r_j + ONE;
                n_st  = E_SHDN_RD;
            end
            E_COPY_RD: begin
                if (r_j < cur_cnt) begin
                    re    = 1'b1;
                    raddr = addr_of(r_tbl, r_j);
                    n_st  = E_COPY_WR;
                end else begin
                    n_st = E_DONE;
                end
            end
            E_COPY_WR: begin
                we    = 1'b1;
                waddr = addr_of(TB_SNAP, r_j);
                wdata = q;
                n_j   = r_j + ONE;
                n_st  = E_COPY_RD;
            end
            E_SNAP_DATA: begin
                n_ent = q;
                n_st  = E_DONE;
            end
            E_DONE: begin
                o_done = 1'b1;
                n_st   = E_IDLE;
            end
            default: n_st = E_IDLE;
        endcase
    end

    // count bookkeeping for the table in use
    always_comb begin
        n_cnt_p = r_cnt_p;
        n_cnt_s = r_cnt_s;
        n_cnt_b = r_cnt_b;
        if (inc || dec) begin
            unique case (r_tbl)
                TB_PRIM: n_cnt_p = inc ? r_cnt_p + ONE : r_cnt_p - ONE;
                TB_SECD: n_cnt_s = inc ? r_cnt_s + ONE : r_cnt_s - ONE;
                TB_BLKD: n_cnt_b = inc ? r_cnt_b + ONE : r_cnt_b - ONE;
                default: ;
            endcase
        end
    end

    assign o_res   = '{found: r_found, full: r_full, ent: r_ent};
    assign o_count = cur_cnt;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held over two cycles");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_st == E_IDLE) else $error("request while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_p <= FULL_CNT && r_cnt_s <= FULL_CNT && r_cnt_b <= FULL_CNT)
        else $error("table count past depth");
    a_no_full_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inc |-> cur_cnt < FULL_CNT) else $error("insert into full table");
endmodule
`default_nettype wire

[rtl/core/sorted_three_list_key_table.sv]
`default_nettype none
// Three key tables (primary, secondary, blocked) kept sorted by signed key in one
// RAM with one write port, one read port and a registered read, driven by a
// sequencer that does one RAM access per step. One request is handled at a time;
// the result waits in an output register while the next request is taken. A lookup
// is a binary search; an insert or a remove moves every entry behind its position
// by one place, with a read and a write for each entry moved. Update_all copies the
// table into a snapshot area and then runs a lookup, remove and insert for each
// matching entry.
module sorted_three_list_key_table
    import sttkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_req       i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_resp           o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);
    localparam int W_CNT = $clog2(TABLE_DEPTH + 1);
    localparam logic [W_CNT-1:0] ONE = W_CNT'(1);

    t_tst             r_st, n_st;
    t_step            r_step, n_step;
    t_req             r_req, n_req;
    t_cmd             r_cmd, n_cmd;
    logic             r_start, n_start;
    logic [W_CNT-1:0] r_i, n_i, r_n, n_n;
    t_ent             r_se, n_se;
    logic             r_ok, n_ok;
    t_resp            r_res, n_res;
    t_resp            r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_norm;

    logic             e_done;
    t_res             e_res;
    logic [W_CNT-1:0] e_count;

    sttkt_engine #(.DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cmd   (r_cmd),
        .i_idx   (r_i),
        .o_done  (e_done),
        .o_res   (e_res),
        .o_count (e_count)
    );

    function automatic t_tbl route(logic [7:0] st, logic [7:0] norm);
        return (st == norm) ? TB_PRIM : TB_SECD;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= T_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_norm      <= '0;
        end else begin
            r_st        <= n_st;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_norm <= i_cfg_data;
            end
        end
        r_step <= n_step;
        r_req  <= n_req;
        r_cmd  <= n_cmd;
        r_i    <= n_i;
        r_n    <= n_n;
        r_se   <= n_se;
        r_ok   <= n_ok;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        n_st = r_st; n_step = r_step; n_req = r_req; n_cmd = r_cmd;
        n_start = 1'b0; n_i = r_i; n_n = r_n; n_se = r_se; n_ok = r_ok;
        n_res = r_res; n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready = 1'b0;
        unique case (r_st)
            T_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_res   = '0;
                    n_ok    = 1'b1;
                    n_start = 1'b1;
                    n_st    = T_WAIT;
                    unique case (i_in_data.func)
                        FN_GET: begin
                            n_cmd  = mk_cmd(PO_FIND, TB_PRIM, i_in_data.user_key, '0, '0);
                            n_step = ST_GET_P;
                        end
                        FN_ADD: begin
                            n_cmd  = mk_cmd(PO_UPSERT, route(i_in_data.entry_state, r_norm),
                                i_in_data.user_key, i_in_data.page_id, i_in_data.entry_state);
                            n_step = ST_ONE_UP;
                        end
                        FN_REMOVE: begin
                            n_cmd  = mk_cmd(PO_ERASE, TB_PRIM, i_in_data.user_key, '0, '0);
                            n_step = ST_RM_P;
                        end
                        FN_UPDATE: begin
                            n_cmd  = mk_cmd(PO_ERASE, TB_PRIM, i_in_data.user_key, '0, '0);
                            n_step = ST_UPD_P;
                        end
                        FN_UPDATE_ALL: begin
                            n_cmd  = mk_cmd(PO_COPY, route(i_in_data.entry_state, r_norm),
                                '0, '0, '0);
                            n_step = ST_UA_COPY;
                        end
                        FN_IS_MEMBER: begin
                            n_cmd  = mk_cmd(PO_FIND, TB_PRIM, i_in_data.user_key, '0, '0);
                            n_step = ST_ONE_HIT;
                        end
                        FN_BLOCK_ADD: begin
                            n_cmd  = mk_cmd(PO_UPSERT, TB_BLKD, i_in_data.user_key,
                                i_in_data.page_id, i_in_data.entry_state);
                            n_step = ST_ONE_UP;
                        end
                        FN_BLOCK_FIND: begin
                            n_cmd  = mk_cmd(PO_FIND, TB_BLKD, i_in_data.user_key, '0, '0);
                            n_step = ST_ONE_HIT;
                        end
                        FN_BLOCK_REMOVE: begin
                            n_cmd  = mk_cmd(PO_ERASE, TB_BLKD, i_in_data.user_key, '0, '0);
                            n_step = ST_ONE_HIT;
                        end
                        default: begin
                            n_start = 1'b0;
                            n_st    = T_FINISH;
                        end
                    endcase
                end
            end
            T_WAIT: begin
                if (e_done) begin
                    unique case (r_step)
                        ST_GET_P, ST_GET_S: begin
                            if (e_res.found) begin
                                n_res.hit         = 1'b1;
                                n_res.found_key   = e_res.ent.key;
                                n_res.found_page  = e_res.ent.page;
                                n_res.found_state = e_res.ent.state;
                                n_st              = T_FINISH;
                            end else if (r_step == ST_GET_P) begin
                                n_cmd   = mk_cmd(PO_FIND, TB_SECD, r_req.user_key, '0, '0);
                                n_start = 1'b1;
                                n_step  = ST_GET_S;
                            end else begin
                                n_st = T_FINISH;
                            end
                        end
                        ST_ONE_UP: begin
                            n_res.hit        = e_res.found;
                            n_res.table_full = e_res.full;
                            n_st             = T_FINISH;
                        end
                        ST_ONE_HIT: begin
                            n_res.hit = e_res.found;
                            n_st      = T_FINISH;
                        end
                        ST_RM_P: begin
                            if (e_res.found) begin
                                n_res.hit = 1'b1;
                                n_st      = T_FINISH;
                            end else begin
                                n_cmd   = mk_cmd(PO_ERASE, TB_SECD, r_req.user_key, '0, '0);
                                n_start = 1'b1;
                                n_step  = ST_ONE_HIT;
                            end
                        end
                        ST_UPD_P, ST_UPD_S: begin
                            if (e_res.found) begin
                                n_cmd   = mk_cmd(PO_UPSERT, route(r_req.entry_state, r_norm),
                                    r_req.user_key, r_req.page_id, r_req.entry_state);
                                n_start = 1'b1;
                                n_step  = ST_ONE_UP;
                            end else if (r_step == ST_UPD_P) begin
                                n_cmd   = mk_cmd(PO_ERASE, TB_SECD, r_req.user_key, '0, '0);
                                n_start = 1'b1;
                                n_step  = ST_UPD_S;
                            end else begin
                                n_res.hit = 1'b1;
                                n_st      = T_FINISH;
                            end
                        end
                        ST_UA_COPY: begin
                            n_n  = e_count;
                            n_i  = '0;
                            n_st = T_UA_NEXT;
                        end
                        ST_UA_SNAP: begin
                            n_se = e_res.ent;
                            if (e_res.ent.state == r_req.entry_state) begin
                                n_cmd   = mk_cmd(PO_FIND, route(r_req.entry_state, r_norm),
                                    e_res.ent.key, '0, '0);
                                n_start = 1'b1;
                                n_step  = ST_UA_FIND;
                            end else begin
                                n_i  = r_i + ONE;
                                n_st = T_UA_NEXT;
                            end
                        end
                        ST_UA_FIND: begin
                            n_start = 1'b1;
                            if (e_res.found) begin
                                n_cmd  = mk_cmd(PO_SETST, route(r_req.entry_state, r_norm),
                                    '0, '0, r_req.target_state);
                                n_step = ST_UA_SET;
                            end else begin
                                n_cmd  = mk_cmd(PO_ERASE, TB_PRIM, r_se.key, '0, '0);
                                n_step = ST_UA_RMP;
                            end
                        end
                        ST_UA_SET: begin
                            n_cmd   = mk_cmd(PO_ERASE, TB_PRIM, r_se.key, '0, '0);
                            n_start = 1'b1;
                            n_step  = ST_UA_RMP;
                        end
                        ST_UA_RMP, ST_UA_RMS: begin
                            n_start = 1'b1;
                            if (e_res.found || r_step == ST_UA_RMS) begin
                                n_cmd  = mk_cmd(PO_UPSERT, route(r_req.target_state, r_norm),
                                    r_se.key, r_se.page, r_req.target_state);
                                n_step = ST_UA_ADD;
                            end else begin
                                n_cmd  = mk_cmd(PO_ERASE, TB_SECD, r_se.key, '0, '0);
                                n_step = ST_UA_RMS;
                            end
                        end
                        ST_UA_ADD: begin
                            if (!e_res.found) begin
                                n_ok = 1'b0;
                            end
                            n_i  = r_i + ONE;
                            n_st = T_UA_NEXT;
                        end
                        default: n_st = T_FINISH;
                    endcase
                end
            end
            T_UA_NEXT: begin
                if (r_i < r_n) begin
                    n_cmd   = mk_cmd(PO_RDSNAP, TB_SNAP, '0, '0, '0);
                    n_start = 1'b1;
                    n_step  = ST_UA_SNAP;
                    n_st    = T_WAIT;
                end else begin
                    n_res.hit        = r_ok;
                    n_res.table_full = !r_ok;
                    n_st             = T_FINISH;
                end
            end
            T_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_st        = T_IDLE;
                end
            end
            default: n_st = T_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
endmodule
`default_nettype wire
